/* rtl/rfp_pkg.sv */
package rfp_pkg;

    // Widths of the configuration registers and of the write port.
    localparam int ARG_LIMIT_W = 5;
    localparam int LEN_LIMIT_W = 21;
    localparam int CFG_DATA_W  = LEN_LIMIT_W;
    localparam int CFG_IDX_W   = 1;

    // Largest values the limit registers can hold.
    localparam int unsigned     ARG_LIMIT_MAX = (1 << ARG_LIMIT_W) - 1;
    localparam longint unsigned LEN_LIMIT_MAX = (64'd1 << LEN_LIMIT_W) - 64'd1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ARG_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_LIMIT = 1'b1;

    // Reset values of the limit registers.
    localparam logic [ARG_LIMIT_W-1:0] ARG_LIMIT_RST = 5'd16;
    localparam logic [LEN_LIMIT_W-1:0] LEN_LIMIT_RST = 21'd1048576;

    // Defaults of the top level parameters.
    localparam int unsigned     MAX_ARGS_DEF = 16;
    localparam longint unsigned MAX_BULK_DEF = 64'd1048576;

    // Result kinds.
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_ARG_END = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Error codes.
    localparam logic [2:0] ERR_BAD_START  = 3'd0;
    localparam logic [2:0] ERR_NON_DIGIT  = 3'd1;
    localparam logic [2:0] ERR_MISSING_LF = 3'd2;
    localparam logic [2:0] ERR_NO_DOLLAR  = 3'd3;
    localparam logic [2:0] ERR_OVER_LIMIT = 3'd4;

    // Stream characters.
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [3:0] arg_index;
        logic       last_of_command;
        logic [2:0] error_code;
    } rfp_result_t;

endpackage

/* rtl/rfp_fsm.sv */
module rfp_fsm
    import rfp_pkg::*;
#(
    parameter int unsigned     MAX_ARGS = MAX_ARGS_DEF,
    parameter longint unsigned MAX_BULK = MAX_BULK_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic [7:0]             item_byte,
    output logic                   take,
    input  logic [ARG_LIMIT_W-1:0] arg_limit,
    input  logic [LEN_LIMIT_W-1:0] len_limit,
    output logic                   out_valid,
    input  logic                   out_stall,
    output rfp_result_t            out_result
);

    // Effective ceilings: limit register values above these are clamped to them.
    localparam int unsigned     CNT_CAP = (MAX_ARGS < ARG_LIMIT_MAX) ? MAX_ARGS : ARG_LIMIT_MAX;
    localparam longint unsigned LEN_CAP = (MAX_BULK < LEN_LIMIT_MAX) ? MAX_BULK : LEN_LIMIT_MAX;
    localparam int CNT_W = $clog2(CNT_CAP + 1);
    localparam int LEN_W = $clog2(LEN_CAP + 1);
    localparam int ACC_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int MUL_W = ACC_W + 4;

    typedef enum logic [3:0] {
        PH_START,
        PH_RESYNC,
        PH_COUNT,
        PH_COUNTLF,
        PH_DOLLAR,
        PH_LEN,
        PH_LENLF,
        PH_DATA,
        PH_TRAIL1,
        PH_TRAIL2
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] args_rem_reg, args_rem_next;
    logic [3:0]       cur_arg_reg, cur_arg_next;
    logic [LEN_W-1:0] bytes_rem_reg, bytes_rem_next;
    logic             out_valid_reg, out_valid_next;
    rfp_result_t      out_res_reg, out_res_next;

    logic [CNT_W-1:0] cnt_cap;
    logic [LEN_W-1:0] len_cap;
    logic [ACC_W-1:0] cap_sel;
    logic [MUL_W-1:0] acc_x10;
    logic             is_digit;
    logic             over;
    logic             res_hit;
    rfp_result_t      res;

    assign take = item_valid && (!out_valid_reg || !out_stall);

    assign cnt_cap = (32'(arg_limit) < CNT_CAP) ? CNT_W'(arg_limit) : CNT_W'(CNT_CAP);
    assign len_cap = (64'(len_limit) < LEN_CAP) ? LEN_W'(len_limit) : LEN_W'(LEN_CAP);
    assign cap_sel = (phase_reg == PH_COUNT) ? ACC_W'(cnt_cap) : ACC_W'(len_cap);

    // acc * 10 + digit, built from two shifts.
    assign acc_x10 = MUL_W'({acc_reg, 3'b000}) + MUL_W'({acc_reg, 1'b0})
                   + MUL_W'(item_byte[3:0]);
    assign is_digit = (item_byte >= CH_ZERO) && (item_byte <= CH_NINE);
    assign over     = acc_x10 > MUL_W'(cap_sel);

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        args_rem_next  = args_rem_reg;
        cur_arg_next   = cur_arg_reg;
        bytes_rem_next = bytes_rem_reg;
        res_hit        = 1'b0;
        res            = '0;

        if (take)
        begin
            unique case (phase_reg)
                PH_START, PH_RESYNC:
                begin
                    if (item_byte == CH_STAR)
                    begin
                        acc_next   = '0;
                        phase_next = PH_COUNT;
                    end
                    else if (phase_reg == PH_START)
                    begin
                        phase_next     = PH_RESYNC;
                        res_hit        = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_BAD_START;
                    end
                end
                PH_COUNT, PH_LEN:
                begin
                    if (item_byte == CH_CR)
                    begin
                        phase_next = (phase_reg == PH_COUNT) ? PH_COUNTLF : PH_LENLF;
                    end
                    else if (!is_digit || over)
                    begin
                        phase_next     = PH_RESYNC;
                        res_hit        = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = is_digit ? ERR_OVER_LIMIT : ERR_NON_DIGIT;
                    end
                    else
                    begin
                        acc_next = acc_x10[ACC_W-1:0];
                    end
                end
                PH_COUNTLF:
                begin
                    if (item_byte != CH_LF)
                    begin
                        phase_next     = PH_RESYNC;
                        res_hit        = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_MISSING_LF;
                    end
                    else if (acc_reg == '0)
                    begin
                        phase_next          = PH_START;
                        res_hit             = 1'b1;
                        res.kind            = KIND_EMPTY;
                        res.last_of_command = 1'b1;
                    end
                    else
                    begin
                        args_rem_next = acc_reg[CNT_W-1:0];
                        cur_arg_next  = '0;
                        phase_next    = PH_DOLLAR;
                    end
                end
                PH_DOLLAR:
                begin
                    if (item_byte != CH_DOLLAR)
                    begin
                        phase_next     = PH_RESYNC;
                        res_hit        = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_NO_DOLLAR;
                    end
                    else
                    begin
                        acc_next   = '0;
                        phase_next = PH_LEN;
                    end
                end
                PH_LENLF:
                begin
                    if (item_byte != CH_LF)
                    begin
                        phase_next     = PH_RESYNC;
                        res_hit        = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_MISSING_LF;
                    end
                    else
                    begin
                        bytes_rem_next = acc_reg[LEN_W-1:0];
                        phase_next     = (acc_reg == '0) ? PH_TRAIL1 : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    res_hit       = 1'b1;
                    res.kind      = KIND_DATA;
                    res.data_byte = item_byte;
                    res.arg_index = cur_arg_reg;
                    if (bytes_rem_reg != '0)
                    begin
                        bytes_rem_next = bytes_rem_reg - LEN_W'(1);
                    end
                    if (bytes_rem_reg <= LEN_W'(1))
                    begin
                        phase_next = PH_TRAIL1;
                    end
                end
                PH_TRAIL1:
                begin
                    phase_next = PH_TRAIL2;
                end
                PH_TRAIL2:
                begin
                    res_hit             = 1'b1;
                    res.kind            = KIND_ARG_END;
                    res.arg_index       = cur_arg_reg;
                    res.last_of_command = args_rem_reg <= CNT_W'(1);
                    if (args_rem_reg != '0)
                    begin
                        args_rem_next = args_rem_reg - CNT_W'(1);
                    end
                    cur_arg_next = cur_arg_reg + 4'd1;
                    phase_next   = (args_rem_reg <= CNT_W'(1)) ? PH_START : PH_DOLLAR;
                end
                default:
                begin
                    phase_next = PH_RESYNC;
                end
            endcase
        end
    end

    // The result register is reloaded whenever an item is parsed; otherwise
    // it empties once the receiver takes it.
    always_comb
    begin
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = res_hit;
            out_res_next   = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            acc_reg       <= '0;
            args_rem_reg  <= '0;
            cur_arg_reg   <= '0;
            bytes_rem_reg <= '0;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            args_rem_reg  <= args_rem_next;
            cur_arg_reg   <= cur_arg_next;
            bytes_rem_reg <= bytes_rem_next;
            out_valid_reg <= out_valid_next;
            out_res_reg   <= out_res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_res_reg;

endmodule

/* rtl/resp_command_frame_parser.sv */
// Request frame parser: '*' count CR LF, then per argument '$' length CR LF,
// payload bytes and two trailing bytes.
// Input channel: in_valid / in_stall / in_byte, one stream byte per item.
// Output channel: out_valid / out_stall with kind, data_byte, arg_index,
// last_of_command and error_code. Each input item gives zero or one result.
// Limits are written through cfg_we / cfg_index / cfg_data while idle; the
// user must keep to this, as the block itself does not enforce it.
// An accepted item is held in the input register until the parser takes it;
// the parser's result for it (if any) is loaded into the result register.
// Throughput: one item per cycle while the receiver does not stall; the input
// register and the result register decouple the two sides, and the whole
// state update for one byte sits between them.
// When the receiver stalls on a held result, the result register holds and
// the parser stops; the input register absorbs at most one more item and
// then in_stall rises.
// Reset clears the parser to wait for a frame start, empties both registers
// and restores the limits to 16 arguments and 1048576 bytes.
module resp_command_frame_parser
    import rfp_pkg::*;
#(
    parameter int unsigned     MAX_ARGS = MAX_ARGS_DEF,
    parameter longint unsigned MAX_BULK = MAX_BULK_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            in_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            kind,
    output logic [7:0]            data_byte,
    output logic [3:0]            arg_index,
    output logic                  last_of_command,
    output logic [2:0]            error_code,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg, in_byte_next;
    logic [ARG_LIMIT_W-1:0] arg_limit_reg, arg_limit_next;
    logic [LEN_LIMIT_W-1:0] len_limit_reg, len_limit_next;
    logic                   take;
    logic                   accept;
    rfp_result_t            result;

    assign in_stall = in_valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = in_byte;
        end
        else if (take)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        arg_limit_next = arg_limit_reg;
        len_limit_next = len_limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ARG_LIMIT: arg_limit_next = cfg_data[ARG_LIMIT_W-1:0];
                CFG_LEN_LIMIT: len_limit_next = cfg_data[LEN_LIMIT_W-1:0];
                default:       arg_limit_next = arg_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            arg_limit_reg <= ARG_LIMIT_RST;
            len_limit_reg <= LEN_LIMIT_RST;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            arg_limit_reg <= arg_limit_next;
            len_limit_reg <= len_limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
    end

    rfp_fsm #(
        .MAX_ARGS (MAX_ARGS),
        .MAX_BULK (MAX_BULK)
    ) u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item_byte  (in_byte_reg),
        .take       (take),
        .arg_limit  (arg_limit_reg),
        .len_limit  (len_limit_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (result)
    );

    assign kind            = result.kind;
    assign data_byte       = result.data_byte;
    assign arg_index       = result.arg_index;
    assign last_of_command = result.last_of_command;
    assign error_code      = result.error_code;

endmodule

/* rtl/rfp_checker.sv */
module rfp_checker
    import rfp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] kind,
    input logic [7:0] data_byte,
    input logic [3:0] arg_index,
    input logic       last_of_command,
    input logic [2:0] error_code
);

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
            && $stable(arg_index) && $stable(last_of_command) && $stable(error_code))
        else $error("result changed while stalled");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DATA |-> data_byte == 8'd0)
        else $error("data_byte set on a non-payload result");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_ERROR) ? (error_code <= ERR_OVER_LIMIT)
                                            : (error_code == ERR_BAD_START))
        else $error("error_code inconsistent with kind");

    a_empty_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_EMPTY || kind == KIND_ERROR)
            |-> arg_index == 4'd0 && last_of_command == (kind == KIND_EMPTY))
        else $error("empty command or error result malformed");

endmodule

bind resp_command_frame_parser rfp_checker u_rfp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .data_byte       (data_byte),
    .arg_index       (arg_index),
    .last_of_command (last_of_command),
    .error_code      (error_code)
);
